[hdl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPL(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

[hdl/sdcc_pkg.sv]
`default_nettype none

package sdcc_pkg;

  localparam int WINDOW_LEN = 8;
  localparam int STEP_TIMES = 4;

  localparam int READ_W   = 10;
  localparam int TS_W     = 32;
  localparam int PERIOD_W = 16;
  localparam int THR_W    = 10;
  localparam int RATE_W   = 2;

  // running sum of the window, wide enough for WINDOW_LEN full-scale readings
  localparam int SUM_W = READ_W + $clog2(WINDOW_LEN);

  // exact divide by WINDOW_LEN through a reciprocal multiply
  localparam int DIV_SH  = SUM_W + $clog2(WINDOW_LEN);
  localparam int DIV_MUL = (2 ** DIV_SH + WINDOW_LEN - 1) / WINDOW_LEN;
  localparam int PROD_W  = SUM_W + DIV_SH + 1;

  localparam logic [TS_W-1:0] NOT_READY_LIMIT = TS_W'(100);

  // in packed stream layout
  localparam int S_DATA_W = 48;
  localparam int M_DATA_W = 16;

  typedef enum logic [RATE_W-1:0] {
    RATE_NOT_READY  = 2'd0,
    RATE_STATIONARY = 2'd1,
    RATE_WALKING    = 2'd2,
    RATE_RUNNING    = 2'd3
  } rate_t;

  typedef enum logic [1:0] {
    CFG_AMP_THRESHOLD = 2'd0,
    CFG_WALK_PERIOD   = 2'd1,
    CFG_RUN_PERIOD    = 2'd2
  } cfg_reg_t;

  function automatic rate_t classify(input logic            not_ready,
                                     input logic [TS_W-1:0] full_span,
                                     input logic [TS_W-1:0] step_span,
                                     input logic [PERIOD_W-1:0] walk_period,
                                     input logic [PERIOD_W-1:0] run_period);
    logic [TS_W-1:0] walk_ext;
    logic [TS_W-1:0] run_ext;
    rate_t           rate;
    walk_ext = {{(TS_W-PERIOD_W){1'b0}}, walk_period};
    run_ext  = {{(TS_W-PERIOD_W){1'b0}}, run_period};
    if (not_ready) begin
      rate = RATE_NOT_READY;
    end else if (full_span > walk_ext) begin
      rate = RATE_STATIONARY;
    end else if (step_span < run_ext) begin
      rate = RATE_RUNNING;
    end else if (step_span < walk_ext) begin
      rate = RATE_WALKING;
    end else begin
      rate = RATE_STATIONARY;
    end
    return rate;
  endfunction

endpackage

`default_nettype wire

[hdl/step_detect_cadence_classifier_top.sv]
`default_nettype none

// Step detector with cadence classifier. Each input transaction carries a
// 10-bit sensor reading and a 32-bit millisecond timestamp; each one yields
// exactly one output transaction with the truncated average of the last
// WINDOW_LEN readings, a step flag (rising crossing of the amplitude
// threshold) and a movement class built from the last STEP_TIMES step
// timestamps: 0 not ready, 1 stationary, 2 walking, 3 running. The block
// takes one transaction per clock cycle, sustained, while the output is not
// stalled. The result is registered: an accepted transaction waits in the
// input register, then the window sum, average, crossing test and span
// compares load the result register. The running window sum and the step
// time list are updated as the result register loads, which sets the rate.
// Both the step-list candidates (shifted and not) are classified in
// parallel and picked by the step flag. Reset clears all state at once; no
// clearing pass is needed. Registers (amplitude threshold, walk period, run
// period) are written over the cfg channel, which is always ready, and must
// only be written while no transaction is in flight.
module step_detect_cadence_classifier_top
  import sdcc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  // input stream
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [S_DATA_W-1:0] s_tdata,   // reading[9:0], timestamp_ms[41:10], zero pad
  // output stream
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [M_DATA_W-1:0]      m_tdata,   // average[9:0], movement_rate[11:10], zero pad
  output logic                     m_tuser,   // step_seen
  // register write channel
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [PERIOD_W-1:0] cfg_data
);

  // configuration registers
  logic [THR_W-1:0]    amplitude_threshold;
  logic [PERIOD_W-1:0] walk_period_ms;
  logic [PERIOD_W-1:0] run_period_ms;

  // input register stage
  logic              in_valid;
  logic [READ_W-1:0] in_reading;
  logic [TS_W-1:0]   in_timestamp;

  // result register stage
  logic              out_valid;
  logic [READ_W-1:0] out_average;
  rate_t             out_rate;
  logic              out_step;

  // detector state
  logic [READ_W-1:0] sample_window [WINDOW_LEN];
  logic [SUM_W-1:0]  window_sum;
  logic [READ_W-1:0] previous_average;
  logic [TS_W-1:0]   step_times [STEP_TIMES];

  // next values
  logic [SUM_W-1:0]  window_sum_next;
  logic [PROD_W-1:0] avg_product;
  logic [READ_W-1:0] average_next;
  logic              step_next;
  rate_t             rate_next;
  rate_t             rate_keep;
  rate_t             rate_shift;

  logic advance;

  // result stage moves when empty or being drained
  assign advance   = !out_valid || m_tready;
  assign s_tready  = !in_valid || advance;
  assign cfg_ready = 1'b1;

  assign m_tvalid = out_valid;
  assign m_tuser  = out_step;
  assign m_tdata  = {{(M_DATA_W-READ_W-RATE_W){1'b0}}, out_rate, out_average};

  // register writes; out-of-range indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      amplitude_threshold <= THR_W'(512);
      walk_period_ms      <= PERIOD_W'(1000);
      run_period_ms       <= PERIOD_W'(500);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_AMP_THRESHOLD: amplitude_threshold <= cfg_data[THR_W-1:0];
        CFG_WALK_PERIOD:   walk_period_ms      <= cfg_data;
        CFG_RUN_PERIOD:    run_period_ms       <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_reading   <= s_tdata[READ_W-1:0];
      in_timestamp <= s_tdata[READ_W +: TS_W];
    end
  end

  // running sum: drop the oldest reading, add the new one
  always_comb begin
    window_sum_next = window_sum
                    - {{(SUM_W-READ_W){1'b0}}, sample_window[0]}
                    + {{(SUM_W-READ_W){1'b0}}, in_reading};
    avg_product  = PROD_W'(window_sum_next) * PROD_W'(DIV_MUL);
    average_next = avg_product[DIV_SH +: READ_W];
    // rising crossing against the current threshold
    step_next = (average_next > amplitude_threshold)
             && !(previous_average > amplitude_threshold);
  end

  // cadence for both possible step lists, picked by the step flag
  always_comb begin
    logic below_keep;
    logic below_shift;
    below_keep  = in_timestamp < NOT_READY_LIMIT;
    below_shift = in_timestamp < NOT_READY_LIMIT;
    // list without shift: old slots 0..STEP_TIMES-2, then now
    for (int i = 0; i < STEP_TIMES - 1; i++) begin
      below_keep = below_keep | (step_times[i] < NOT_READY_LIMIT);
    end
    // list with shift: old slots 1..STEP_TIMES-1, then now
    for (int i = 1; i < STEP_TIMES; i++) begin
      below_shift = below_shift | (step_times[i] < NOT_READY_LIMIT);
    end
    rate_keep  = classify(below_keep,
                          in_timestamp - step_times[0],
                          step_times[STEP_TIMES-2] - step_times[0],
                          walk_period_ms, run_period_ms);
    rate_shift = classify(below_shift,
                          in_timestamp - step_times[1],
                          step_times[STEP_TIMES-1] - step_times[1],
                          walk_period_ms, run_period_ms);
    rate_next  = step_next ? rate_shift : rate_keep;
  end

  // state update as the item leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid        <= 1'b0;
      window_sum       <= '0;
      previous_average <= '0;
      for (int i = 0; i < WINDOW_LEN; i++) begin
        sample_window[i] <= '0;
      end
      for (int i = 0; i < STEP_TIMES; i++) begin
        step_times[i] <= '0;
      end
    end else if (advance) begin
      out_valid <= in_valid;
      if (in_valid) begin
        window_sum       <= window_sum_next;
        previous_average <= average_next;
        for (int i = 0; i < WINDOW_LEN - 1; i++) begin
          sample_window[i] <= sample_window[i+1];
        end
        sample_window[WINDOW_LEN-1] <= in_reading;
        if (step_next) begin
          for (int i = 0; i < STEP_TIMES - 1; i++) begin
            step_times[i] <= step_times[i+1];
          end
        end
        step_times[STEP_TIMES-1] <= in_timestamp;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      out_average <= average_next;
      out_rate    <= rate_next;
      out_step    <= step_next;
    end
  end

endmodule

`default_nettype wire

[hdl/sdcc_checker.sv]
`default_nettype none

`include "assert_macros.svh"

module sdcc_checker
  import sdcc_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                s_tvalid,
  input wire logic                s_tready,
  input wire logic                m_tvalid,
  input wire logic                m_tready,
  input wire logic [M_DATA_W-1:0] m_tdata,
  input wire logic                m_tuser
);

  // transactions accepted but not yet delivered
  logic [1:0] inflight;
  logic [1:0] inflight_next;
  logic       in_take;
  logic       out_take;

  // output side held back, and everything it shows
  logic              stalled;
  logic [M_DATA_W:0] m_word;

  assign in_take  = s_tvalid && s_tready;
  assign out_take = m_tvalid && m_tready;
  assign stalled  = m_tvalid && !m_tready;
  assign m_word   = {m_tuser, m_tdata};

  always_comb begin
    inflight_next = inflight + {1'b0, in_take} - {1'b0, out_take};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight_next;
    end
  end

  `ASSERT_NEXT(a_out_hold, stalled, m_tvalid && $stable(m_word), "output changed while stalled")
  `ASSERT_IMPL(a_no_invented, m_tvalid, inflight != 2'd0, "output without an accepted input")
  `ASSERT_ALWAYS(a_depth, inflight != 2'd3, "more than two transactions in flight")
  `ASSERT_IMPL(a_ready_when_empty, !m_tvalid, s_tready, "input stalled while output empty")
  `ASSERT_IMPL(a_reset_quiet, $past(rst), !m_tvalid, "output valid right after reset")

endmodule

bind step_detect_cadence_classifier_top sdcc_checker u_sdcc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire
